// ===== sv/id3tf_pkg.sv =====
// Shared types, codes and the UTF-8 encoder for the ID3 text frame converter.
`timescale 1ns / 1ps
package id3tf_pkg;

   // Text encodings selected by the first byte of a frame
   typedef enum logic [1:0] {
      MODE_LATIN1  = 2'd0,
      MODE_UTF16   = 2'd1,
      MODE_UTF16BE = 2'd2,
      MODE_UTF8    = 2'd3
   } mode_type;

   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = 3;

   // One queued request: the UTF-8 bytes it produced and its frame flag
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } entry_type;

   // Encoded form of one code point
   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      len;
   } enc_type;

   function automatic enc_type encode(input logic [20:0] cp);
      enc_type e;
      e.b = '0;
      if (cp < 21'h80) begin
         e.b[0] = cp[7:0];
         e.len  = 3'd1;
      end else if (cp < 21'h800) begin
         e.b[0] = {3'b110, cp[10:6]};
         e.b[1] = {2'b10, cp[5:0]};
         e.len  = 3'd2;
      end else if (cp < 21'h10000) begin
         e.b[0] = {4'b1110, cp[15:12]};
         e.b[1] = {2'b10, cp[11:6]};
         e.b[2] = {2'b10, cp[5:0]};
         e.len  = 3'd3;
      end else begin
         e.b[0] = {5'b11110, cp[20:18]};
         e.b[1] = {2'b10, cp[17:12]};
         e.b[2] = {2'b10, cp[11:6]};
         e.b[3] = {2'b10, cp[5:0]};
         e.len  = 3'd4;
      end
      return e;
   endfunction

endpackage

// ===== sv/id3tf_front.sv =====
// Front end: tracks frame decode state and turns each request into a byte group.
`timescale 1ns / 1ps
module id3tf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_frame_last,
   input  logic                 q_ready,
   output logic                 q_push,
   output id3tf_pkg::entry_type q_entry
);

   logic                   expect_ff, expect_in;
   id3tf_pkg::mode_type    mode_ff, mode_in;
   logic                   be_ff, be_in;
   logic                   first_ff, first_in;
   logic                   half_v_ff, half_v_in;
   logic [7:0]             half_b_ff, half_b_in;
   logic                   held_v_ff, held_v_in;
   logic [9:0]             held_ff, held_in;
   logic                   term_ff, term_in;

   logic                   accept;
   logic [15:0]            unit;
   logic                   bom;
   logic                   a_v, s_v, s_raw;
   logic [20:0]            a_cp;
   logic [15:0]            s_cp;
   logic [20:0]            slot0;
   logic                   v0, v1, raw0;
   id3tf_pkg::enc_type     e0, e1;
   logic [2:0]             len0, len1;
   logic [2:0]             j;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign unit      = be_ff ? {half_b_ff, req_data_byte} : {req_data_byte, half_b_ff};

   // Decode the byte against the current frame state
   always_comb begin
      expect_in = expect_ff;
      mode_in   = mode_ff;
      be_in     = be_ff;
      first_in  = first_ff;
      half_v_in = half_v_ff;
      half_b_in = half_b_ff;
      held_v_in = held_v_ff;
      held_in   = held_ff;
      term_in   = term_ff;
      bom       = 1'b0;
      a_v       = 1'b0;
      a_cp      = '0;
      s_v       = 1'b0;
      s_cp      = '0;
      s_raw     = 1'b0;
      if (expect_ff) begin
         expect_in = 1'b0;
         mode_in   = (req_data_byte <= 8'd2) ? id3tf_pkg::mode_type'(req_data_byte[1:0])
                                             : id3tf_pkg::MODE_UTF8;
         be_in     = (mode_in == id3tf_pkg::MODE_UTF16BE);
         first_in  = 1'b1;
         half_v_in = 1'b0;
         half_b_in = '0;
         held_v_in = 1'b0;
         held_in   = '0;
         term_in   = 1'b0;
      end else if (!term_ff) begin
         case (mode_ff)
            id3tf_pkg::MODE_LATIN1, id3tf_pkg::MODE_UTF8: begin
               if (req_data_byte == 8'd0) begin
                  term_in = 1'b1;
               end else begin
                  s_v   = 1'b1;
                  s_cp  = {8'd0, req_data_byte};
                  s_raw = (mode_ff == id3tf_pkg::MODE_UTF8);
               end
            end
            default: begin
               if (!half_v_ff) begin
                  half_v_in = 1'b1;
                  half_b_in = req_data_byte;
               end else begin
                  half_v_in = 1'b0;
                  if (first_ff) begin
                     first_in = 1'b0;
                     if (mode_ff == id3tf_pkg::MODE_UTF16) begin
                        if (half_b_ff == 8'hFE && req_data_byte == 8'hFF) begin
                           be_in = 1'b1;
                           bom   = 1'b1;
                        end else if (half_b_ff == 8'hFF && req_data_byte == 8'hFE) begin
                           be_in = 1'b0;
                           bom   = 1'b1;
                        end
                     end
                  end
                  if (!bom) begin
                     if (held_v_ff && (unit inside {[16'hDC00:16'hDFFF]})) begin
                        // combine the surrogate pair
                        a_v       = 1'b1;
                        a_cp      = 21'h10000 + {1'b0, held_ff, unit[9:0]};
                        held_v_in = 1'b0;
                     end else begin
                        // flush a lone high surrogate, then take the unit itself
                        if (held_v_ff) begin
                           a_v       = 1'b1;
                           a_cp      = {5'd0, 6'b110110, held_ff};
                           held_v_in = 1'b0;
                        end
                        if (unit == 16'd0) begin
                           term_in = 1'b1;
                        end else if (unit inside {[16'hD800:16'hDBFF]}) begin
                           held_v_in = 1'b1;
                           held_in   = unit[9:0];
                        end else begin
                           s_v  = 1'b1;
                           s_cp = unit;
                        end
                     end
                  end
               end
            end
         endcase
      end
      // At frame end flush a held surrogate and return to selector state
      if (req_frame_last) begin
         if (!term_in && held_v_in) begin
            s_v   = 1'b1;
            s_cp  = {6'b110110, held_in};
            s_raw = 1'b0;
         end
         expect_in = 1'b1;
         mode_in   = id3tf_pkg::MODE_LATIN1;
         be_in     = 1'b0;
         first_in  = 1'b1;
         half_v_in = 1'b0;
         half_b_in = '0;
         held_v_in = 1'b0;
         held_in   = '0;
         term_in   = 1'b0;
      end
   end

   // Encode up to two code points and pack their bytes
   always_comb begin
      slot0 = a_v ? a_cp : {5'd0, s_cp};
      raw0  = !a_v && s_raw;
      v0    = a_v || s_v;
      v1    = a_v && s_v;
      e0    = id3tf_pkg::encode(slot0);
      if (raw0) begin
         e0.b   = {24'd0, s_cp[7:0]};
         e0.len = 3'd1;
      end
      e1   = id3tf_pkg::encode({5'd0, s_cp});
      len0 = v0 ? e0.len : 3'd0;
      len1 = v1 ? e1.len : 3'd0;
      q_entry.count = len0 + len1;
      q_entry.last  = req_frame_last;
      for (int i = 0; i < id3tf_pkg::MAX_BYTES; i++) begin
         j = 3'(i) - len0;
         if (3'(i) < len0) begin
            q_entry.bytes[i] = e0.b[i[1:0]];
         end else if (j < 3'd4) begin
            q_entry.bytes[i] = e1.b[j[1:0]];
         end else begin
            q_entry.bytes[i] = 8'd0;
         end
      end
   end

   assign q_push = accept && (q_entry.count != 3'd0 || req_frame_last);

   // Hold decode state, advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         mode_ff   <= id3tf_pkg::MODE_LATIN1;
         be_ff     <= 1'b0;
         first_ff  <= 1'b1;
         half_v_ff <= 1'b0;
         held_v_ff <= 1'b0;
         term_ff   <= 1'b0;
      end else if (accept) begin
         expect_ff <= expect_in;
         mode_ff   <= mode_in;
         be_ff     <= be_in;
         first_ff  <= first_in;
         half_v_ff <= half_v_in;
         held_v_ff <= held_v_in;
         term_ff   <= term_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         half_b_ff <= half_b_in;
         held_ff   <= held_in;
      end
   end

endmodule

// ===== sv/id3tf_fifo.sv =====
// Short request queue between the decode front end and the byte serializer.
`timescale 1ns / 1ps
module id3tf_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  id3tf_pkg::entry_type push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output id3tf_pkg::entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   id3tf_pkg::entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, rd_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers and the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/id3tf_back.sv =====
// Back end: serializes queued byte groups onto the response channel.
`timescale 1ns / 1ps
module id3tf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  id3tf_pkg::entry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_valid,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_end
);

   logic [2:0]  idx_ff;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        ovalid_ff, run_last_ff, frame_end_ff;
   logic        load, fin, empty;

   assign load  = head_valid && (!valid_ff || rsp_ready);
   assign empty = (head_entry.count == 3'd0);
   assign fin   = empty || (idx_ff == head_entry.count - 3'd1);
   assign pop   = load && fin;

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_valid = ovalid_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

   // Step through the head group one byte per response
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= fin ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff      <= empty ? 8'd0 : head_entry.bytes[idx_ff];
         ovalid_ff    <= !empty;
         run_last_ff  <= fin;
         frame_end_ff <= fin && head_entry.last;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid && !empty |-> idx_ff < head_entry.count)
      else $error("byte index past end of group");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == 3'd0)
      else $error("byte index left mid-group with queue empty");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !ovalid_ff |-> run_last_ff && frame_end_ff)
      else $error("empty response not marked as frame end");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && frame_end_ff |-> run_last_ff)
      else $error("frame end without run end");

endmodule

// ===== sv/id3_text_frame_to_utf8.sv =====
// Top level of the ID3 text frame to UTF-8 converter.
//
//   channel | direction | ports                                     | handshake
//   req     | in        | req_data_byte, req_frame_last             | req_valid / req_ready
//   rsp     | out       | rsp_out_byte, rsp_out_valid, rsp_run_last, | rsp_valid / rsp_ready
//           |           | rsp_frame_end                              |
//
// A request is accepted in any cycle the queue has a free slot; decode is done in
// the same cycle. The serializer sends one response byte per cycle while rsp_ready
// is high: a request gives one response per byte produced (at most six), a frame's
// last byte with no bytes gives one, and any other request without bytes gives none.
// The response is registered; a stalled rsp_ready backs up the queue and then req.
// Reset is synchronous; after it the block expects a selector byte.
`timescale 1ns / 1ps
module id3_text_frame_to_utf8 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic                 q_push, q_ready, q_pop, q_head_valid;
   id3tf_pkg::entry_type q_entry, q_head;

   id3tf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_frame_last (req_frame_last),
      .q_ready        (q_ready),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   id3tf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   id3tf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_head_valid),
      .head_entry    (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
